FILE: sv/crte_pkg.sv
// ----------------------------------------------------------------------------
// crte_pkg
// Shared types and constants for the craps randomness test engine.
// ----------------------------------------------------------------------------
package crte_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgGamesLimit = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgThrowLimit = CfgIdxW'(1);

  localparam logic [31:0] GamesLimitRst = 32'd200000;
  localparam logic [31:0] ThrowLimitRst = 32'hFFFF_FFFF;

  localparam logic [3:0] SumNatural5  = 4'd5;
  localparam logic [3:0] SumNatural9  = 4'd9;
  localparam logic [3:0] SumCrapsLow0 = 4'd0;
  localparam logic [3:0] SumCrapsLow1 = 4'd1;
  localparam logic [3:0] SumCraps10   = 4'd10;
  localparam logic [3:0] SumSevenOut  = 4'd5;

  localparam logic OpThrow = 1'b0;
  localparam logic OpRead  = 1'b1;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  dice_sum;
    logic        game_decided;
    logic        game_won;
    logic [4:0]  decision_bin;
    logic [31:0] games_played;
    logic [31:0] games_won;
    logic [31:0] bin_count;
  } crte_result_t;

  // zero-based die face: (word * 6) >> 32
  function automatic logic [2:0] face_of(input logic [31:0] word);
    logic [34:0] prod;
    prod = {1'b0, word, 2'b00} + {2'b00, word, 1'b0};
    return prod[34:32];
  endfunction

endpackage

FILE: sv/craps_randomness_test_engine.sv
// ----------------------------------------------------------------------------
// craps_randomness_test_engine
// Counting stage of the craps randomness test over a random word stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one beat is either a throw
//   (opcode 0, two 32-bit random words) or a histogram read (opcode 1,
//   bin_select). Every beat yields exactly one result beat on the output
//   channel (out_valid_o/out_ready_i) with game counters and read data.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 writes games_limit,
//   index 1 writes throw_limit; always ready, write only while idle.
//   Output: each result is registered into the head or, if that is occupied, the skid register.
//   Throughput: one beat per cycle while in_ready_o is high; the game update is a single pass of
//   compares and counter increments between the state and output registers.
//   Stall: a two-entry output register (head plus skid) keeps in_ready_o
//   high while one result waits; in_ready_o drops only when both are full.
//   Reset: counters, game state and all histogram bins clear to zero, the
//   limits return to 200000 and 0xFFFFFFFF, the output holds no beat.
// ----------------------------------------------------------------------------
module craps_randomness_test_engine #(
  parameter int unsigned BIN_CAP = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [4:0]                   bin_select_i,
  input  logic [31:0]                  die_a_word_i,
  input  logic [31:0]                  die_b_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic [3:0]                   dice_sum_o,
  output logic                         game_decided_o,
  output logic                         game_won_o,
  output logic [4:0]                   decision_bin_o,
  output logic [31:0]                  games_played_o,
  output logic [31:0]                  games_won_o,
  output logic [31:0]                  bin_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [crte_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import crte_pkg::*;

  localparam int unsigned NumBins = BIN_CAP + 1;
  localparam int unsigned CntW    = $clog2(NumBins);

  logic [31:0]     games_limit_q, throw_limit_q;
  logic [31:0]     hist_q [NumBins];
  logic [NumBins-1:0] hist_inc;
  logic [31:0]     game_count_q, game_count_d;
  logic [31:0]     win_count_q, win_count_d;
  logic [31:0]     throws_seen_q, throws_seen_d;
  logic [3:0]      point_q, point_d;
  logic            in_point_q, in_point_d;
  logic [CntW-1:0] tig_q, tig_d;

  crte_result_t    res;
  crte_result_t    head_q, head_d, skid_q, skid_d;
  logic            hv_q, hv_d, sv_q, sv_d;

  logic            push, pop, throw_ok, ended, win;
  logic [3:0]      sum;
  logic [CntW-1:0] bin, tig_inc;
  logic [CntW-1:0] rd_idx;
  logic            rd_in_range;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !sv_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = hv_q && out_ready_i;

  assign sum         = {1'b0, face_of(die_a_word_i)} + {1'b0, face_of(die_b_word_i)};
  assign rd_idx      = CntW'(bin_select_i);
  assign rd_in_range = ({2'b00, bin_select_i} < 7'(NumBins));
  assign tig_inc     = (tig_q < CntW'(BIN_CAP)) ? tig_q + CntW'(1) : tig_q;

  // game update
  always_comb begin
    throw_ok      = push && (opcode_i == OpThrow) &&
                    (game_count_q < games_limit_q) && (throws_seen_q < throw_limit_q);
    ended         = 1'b0;
    win           = 1'b0;
    bin           = '0;
    point_d       = point_q;
    in_point_d    = in_point_q;
    tig_d         = tig_q;
    throws_seen_d = throws_seen_q;
    game_count_d  = game_count_q;
    win_count_d   = win_count_q;

    if (throw_ok) begin
      throws_seen_d = throws_seen_q + 32'd1;
      if (in_point_q) begin
        tig_d = tig_inc;
        bin   = tig_inc;
        if (sum == point_q) begin
          ended = 1'b1;
          win   = 1'b1;
        end else if (sum == SumSevenOut) begin
          ended = 1'b1;
        end
      end else if (sum == SumNatural5 || sum == SumNatural9) begin
        ended = 1'b1;
        win   = 1'b1;
      end else if (sum == SumCrapsLow0 || sum == SumCrapsLow1 || sum == SumCraps10) begin
        ended = 1'b1;
      end else begin
        in_point_d = 1'b1;
        point_d    = sum;
        tig_d      = '0;
      end
      if (ended) begin
        game_count_d = game_count_q + 32'd1;
        if (win) begin
          win_count_d = win_count_q + 32'd1;
        end
        in_point_d = 1'b0;
        tig_d      = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumBins; i++) begin
      hist_inc[i] = ended && (bin == CntW'(i));
    end
  end

  always_comb begin
    res              = '0;
    res.games_played = game_count_d;
    res.games_won    = win_count_d;
    if (opcode_i == OpRead) begin
      if (rd_in_range) begin
        res.bin_count = hist_q[rd_idx];
      end
    end else if (throw_ok) begin
      res.accepted     = 1'b1;
      res.dice_sum     = sum;
      res.game_decided = ended;
      res.game_won     = win;
      res.decision_bin = ended ? 5'(bin) : 5'd0;
    end
  end

  // head plus skid output register
  always_comb begin
    hv_d   = hv_q;
    sv_d   = sv_q;
    head_d = head_q;
    skid_d = skid_q;
    if (pop) begin
      if (sv_q) begin
        head_d = skid_q;
        sv_d   = 1'b0;
      end else begin
        hv_d = 1'b0;
      end
    end
    if (push) begin
      if (!hv_d) begin
        head_d = res;
        hv_d   = 1'b1;
      end else begin
        skid_d = res;
        sv_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      games_limit_q <= GamesLimitRst;
      throw_limit_q <= ThrowLimitRst;
      game_count_q  <= '0;
      win_count_q   <= '0;
      throws_seen_q <= '0;
      point_q       <= '0;
      in_point_q    <= 1'b0;
      tig_q         <= '0;
      hv_q          <= 1'b0;
      sv_q          <= 1'b0;
      for (int i = 0; i < NumBins; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgGamesLimit: games_limit_q <= cfg_data_i;
          CfgThrowLimit: throw_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      game_count_q  <= game_count_d;
      win_count_q   <= win_count_d;
      throws_seen_q <= throws_seen_d;
      point_q       <= point_d;
      in_point_q    <= in_point_d;
      tig_q         <= tig_d;
      hv_q          <= hv_d;
      sv_q          <= sv_d;
      for (int i = 0; i < NumBins; i++) begin
        if (hist_inc[i]) begin
          hist_q[i] <= hist_q[i] + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = hv_q;
  assign accepted_o     = head_q.accepted;
  assign dice_sum_o     = head_q.dice_sum;
  assign game_decided_o = head_q.game_decided;
  assign game_won_o     = head_q.game_won;
  assign decision_bin_o = head_q.decision_bin;
  assign games_played_o = head_q.games_played;
  assign games_won_o    = head_q.games_won;
  assign bin_count_o    = head_q.bin_count;

endmodule

FILE: sv/crte_checker.sv
// ----------------------------------------------------------------------------
// crte_checker
// Port-level checks for the craps randomness test engine, bound to the top.
// ----------------------------------------------------------------------------
module crte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic [3:0]  dice_sum_o,
  input logic        game_decided_o,
  input logic        game_won_o,
  input logic [4:0]  decision_bin_o,
  input logic [31:0] bin_count_o
);

  // stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // input only blocks when a result is waiting
  a_ready_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with empty output");

  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |->
      !game_decided_o && !game_won_o && dice_sum_o == 4'd0 && decision_bin_o == 5'd0)
    else $error("uncounted beat carries throw fields");

  a_win_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && game_won_o |-> game_decided_o && accepted_o)
    else $error("win without a decided game");

  a_throw_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> bin_count_o == 32'd0 && dice_sum_o <= 4'd10)
    else $error("bad throw result fields");

endmodule

bind craps_randomness_test_engine crte_checker u_crte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .dice_sum_o     (dice_sum_o),
  .game_decided_o (game_decided_o),
  .game_won_o     (game_won_o),
  .decision_bin_o (decision_bin_o),
  .bin_count_o    (bin_count_o)
);

FILE: tb/craps_checker.sv
// ----------------------------------------------------------------------------
// craps_checker
// Watches the throw, result and register channels of the craps engine. Keeps
// its own game state, histogram and limits, scores every input beat as it is
// taken, and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module craps_checker #(
  parameter int unsigned BinCap = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         opcode_i,
  input  logic [4:0]                   bin_select_i,
  input  logic [31:0]                  die_a_word_i,
  input  logic [31:0]                  die_b_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         accepted_i,
  input  logic [3:0]                   dice_sum_i,
  input  logic                         game_decided_i,
  input  logic                         game_won_i,
  input  logic [4:0]                   decision_bin_i,
  input  logic [31:0]                  games_played_i,
  input  logic [31:0]                  games_won_i,
  input  logic [31:0]                  bin_count_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [crte_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic [31:0]                  fail_count_o,
  output logic [31:0]                  pending_o,
  output logic [31:0]                  games_o,
  output logic [31:0]                  throws_o
);

  import crte_pkg::*;

  logic [31:0]  games_cap;
  logic [31:0]  throws_cap;
  logic [31:0]  decision_tally [0:BinCap];
  logic [31:0]  played;
  logic [31:0]  wins;
  logic [31:0]  throws;
  logic [3:0]   point;
  logic         in_point;
  int unsigned  extra;
  logic [31:0]  mismatches;
  crte_result_t expected_scores [$];
  crte_result_t want;

  assign fail_count_o = mismatches;
  assign games_o      = played;
  assign throws_o     = throws;

  function automatic logic [2:0] die_face(input logic [31:0] word);
    logic [63:0] scaled;
    scaled = {32'd0, word} * 64'd6;
    return scaled[34:32];
  endfunction

  function automatic crte_result_t score_beat(input logic op, input logic [4:0] sel,
                                              input logic [31:0] wa, input logic [31:0] wb);
    crte_result_t r;
    logic [3:0]   sum;
    int unsigned  bin;
    bit           ended;
    bit           win;
    r     = '0;
    bin   = 0;
    ended = 1'b0;
    win   = 1'b0;
    if (op == OpRead) begin
      if (sel <= BinCap) r.bin_count = decision_tally[sel];
    end else if (played < games_cap && throws < throws_cap) begin
      sum = die_face(wa) + die_face(wb);
      throws++;
      r.accepted = 1'b1;
      r.dice_sum = sum;
      if (in_point) begin
        if (extra < BinCap) extra++;
        if (sum == point) begin
          ended = 1'b1;
          win   = 1'b1;
        end else if (sum == SumSevenOut) begin
          ended = 1'b1;
        end
        bin = extra;
      end else if (sum == SumNatural5 || sum == SumNatural9) begin
        ended = 1'b1;
        win   = 1'b1;
      end else if (sum == SumCrapsLow0 || sum == SumCrapsLow1 || sum == SumCraps10) begin
        ended = 1'b1;
      end else begin
        in_point = 1'b1;
        point    = sum;
        extra    = 0;
      end
      if (ended) begin
        if (bin <= BinCap) decision_tally[bin]++;
        if (win) wins++;
        played++;
        in_point         = 1'b0;
        extra            = 0;
        r.game_decided   = 1'b1;
        r.game_won       = win;
        r.decision_bin   = 5'(bin);
      end
    end
    r.games_played = played;
    r.games_won    = wins;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      games_cap  = GamesLimitRst;
      throws_cap = ThrowLimitRst;
      for (int i = 0; i <= BinCap; i++) decision_tally[i] = '0;
      played     = '0;
      wins       = '0;
      throws     = '0;
      point      = '0;
      in_point   = 1'b0;
      extra      = 0;
      mismatches = '0;
      expected_scores.delete();
      pending_o <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgGamesLimit: games_cap = cfg_data_i;
          CfgThrowLimit: throws_cap = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_scores.push_back(score_beat(opcode_i, bin_select_i,
                                             die_a_word_i, die_b_word_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_scores.size() == 0) begin
          $error("result beat with no expected result waiting");
          mismatches++;
        end else begin
          want = expected_scores.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted_i));
          check_field("dice_sum", 32'(want.dice_sum), 32'(dice_sum_i));
          check_field("game_decided", 32'(want.game_decided), 32'(game_decided_i));
          check_field("game_won", 32'(want.game_won), 32'(game_won_i));
          check_field("decision_bin", 32'(want.decision_bin), 32'(decision_bin_i));
          check_field("games_played", want.games_played, games_played_i);
          check_field("games_won", want.games_won, games_won_i);
          check_field("bin_count", want.bin_count, bin_count_i);
        end
      end
      pending_o <= expected_scores.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the craps engine with directed throws and reads, limit register
// sweeps and random well-formed games, raw throws and reads under several idle and stall mixes,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  import crte_pkg::*;

  localparam int unsigned BinCap     = 20;
  localparam int unsigned PhaseBeats = 450;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned CycleLimit = 400000;

  localparam int unsigned MidNone  = 0;
  localparam int unsigned MidHold  = 1;
  localparam int unsigned MidPause = 2;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                opcode_i     = OpThrow;
  logic [4:0]          bin_select_i = '0;
  logic [31:0]         die_a_word_i = '0;
  logic [31:0]         die_b_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                accepted_o;
  logic [3:0]          dice_sum_o;
  logic                game_decided_o;
  logic                game_won_o;
  logic [4:0]          decision_bin_o;
  logic [31:0]         games_played_o;
  logic [31:0]         games_won_o;
  logic [31:0]         bin_count_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [31:0]         cfg_data_i   = '0;

  logic [31:0]         fail_count;
  logic [31:0]         pending;
  logic [31:0]         games_scored;
  logic [31:0]         throws_counted;

  int unsigned         cycles       = 0;
  int unsigned         beats_sent   = 0;
  int unsigned         sender_idle  = 0;
  int unsigned         stall_pct    = 0;
  logic                hold_req     = 1'b0;

  craps_randomness_test_engine #(.BIN_CAP(BinCap)) uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .opcode_i, .bin_select_i, .die_a_word_i, .die_b_word_i,
    .out_valid_o, .out_ready_i, .accepted_o, .dice_sum_o, .game_decided_o, .game_won_o,
    .decision_bin_o, .games_played_o, .games_won_o, .bin_count_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  craps_checker #(.BinCap(BinCap)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .bin_select_i,
    .die_a_word_i, .die_b_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .accepted_i(accepted_o),
    .dice_sum_i(dice_sum_o), .game_decided_i(game_decided_o), .game_won_i(game_won_o),
    .decision_bin_i(decision_bin_o), .games_played_i(games_played_o),
    .games_won_i(games_won_o), .bin_count_i(bin_count_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .games_o(games_scored), .throws_o(throws_counted)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [31:0] face_word(input int unsigned face);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = ((64'(face) << 32) + 64'd5) / 64'd6;
    hi = ((64'(face + 1) << 32) + 64'd5) / 64'd6 - 64'd1;
    case ($urandom_range(3))
      0:       return lo[31:0];
      1:       return hi[31:0];
      default: return 32'(lo + 64'($urandom_range(32'(hi - lo))));
    endcase
  endfunction

  task automatic send_beat(input logic op, input logic [4:0] sel,
                           input logic [31:0] wa, input logic [31:0] wb);
    if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    bin_select_i <= sel;
    die_a_word_i <= wa;
    die_b_word_i <= wb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic throw_sum(input int unsigned sum);
    int unsigned fa;
    fa = $urandom_range((sum > 5) ? 5 : sum, (sum > 5) ? sum - 5 : 0);
    send_beat(OpThrow, 5'($urandom), face_word(fa), face_word(sum - fa));
  endtask

  task automatic read_bin(input logic [4:0] sel);
    send_beat(OpRead, sel, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [31:0] games_cap, input logic [31:0] throws_cap);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgGamesLimit;
    cfg_data_i  <= games_cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgThrowLimit;
    cfg_data_i  <= throws_cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic play_game();
    int unsigned first;
    int unsigned rolls;
    int unsigned s;
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: first = 2;
        1: first = 3;
        2: first = 4;
        3: first = 6;
        4: first = 7;
        default: first = 8;
      endcase
    end else begin
      case ($urandom_range(4))
        0: first = 0;
        1: first = 1;
        2: first = 5;
        3: first = 9;
        default: first = 10;
      endcase
    end
    throw_sum(first);
    if (first inside {2, 3, 4, 6, 7, 8}) begin
      rolls = ($urandom_range(3) == 0) ? $urandom_range(26, 18) : $urandom_range(6);
      repeat (rolls) begin
        s = $urandom_range(10);
        while (s == first || s == 5) s = $urandom_range(10);
        throw_sum(s);
      end
      throw_sum($urandom_range(1) ? first : 5);
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned mid);
    int unsigned start;
    bit          mid_done;
    start       = beats_sent;
    mid_done    = 1'b0;
    sender_idle = idle;
    stall_pct   <= stall;
    while (beats_sent < start + PhaseBeats) begin
      if (!mid_done && beats_sent >= start + PhaseBeats / 3) begin
        mid_done = 1'b1;
        if (mid == MidHold) begin
          hold_req <= 1'b1;
        end else if (mid == MidPause) begin
          wait_idle();
          write_limits(games_scored + 25, ThrowLimitRst);
        end
      end
      case ($urandom_range(99)) inside
        [0:79]:  play_game();
        [80:89]: read_bin(($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(20)));
        default: send_beat(OpThrow, 5'($urandom), $urandom, $urandom);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_limits(GamesLimitRst, ThrowLimitRst);

    // directed: reads at the edges of the histogram, naturals, craps, points
    read_bin(5'd0);
    read_bin(5'd20);
    read_bin(5'd21);
    read_bin(5'd31);
    send_beat(OpThrow, 5'd0, 32'h0000_0000, 32'h0000_0000);
    send_beat(OpThrow, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OpThrow, 5'd7, 32'h2AAA_AAAA, 32'h2AAA_AAAB);
    send_beat(OpThrow, 5'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(OpThrow, 5'd0, 32'hD555_5555, 32'hD555_5556);
    throw_sum(6);
    throw_sum(3);
    throw_sum(6);
    throw_sum(4);
    throw_sum(5);
    throw_sum(2);
    throw_sum(0);
    throw_sum(10);
    throw_sum(2);
    throw_sum(8);
    throw_sum(7);
    throw_sum(5);
    read_bin(5'd0);
    read_bin(5'd1);
    read_bin(5'd3);
    wait_idle();

    // limit registers at and near their extremes
    write_limits(32'd0, ThrowLimitRst);
    repeat (4) send_beat(OpThrow, 5'($urandom), $urandom, $urandom);
    read_bin(5'd31);
    wait_idle();
    write_limits(32'hFFFF_FFFF, 32'd0);
    repeat (4) send_beat(OpThrow, 5'($urandom), $urandom, $urandom);
    wait_idle();
    write_limits(32'hFFFF_FFFF, throws_counted + 6);
    repeat (12) throw_sum($urandom_range(10));
    wait_idle();
    write_limits(games_scored + 3, 32'hFFFF_FFFF);
    repeat (30) throw_sum($urandom_range(10));
    wait_idle();

    write_limits(GamesLimitRst, ThrowLimitRst);
    run_phase(0, 0, MidHold);
    run_phase(66, 0, MidPause);
    write_limits(32'hFFFF_FFFF, ThrowLimitRst);
    run_phase(0, 66, MidNone);
    write_limits(32'hFFFF_FFFF, throws_counted + 300);
    run_phase(33, 33, MidNone);

    repeat (8) @(posedge clk_i);
    $display("Run covered %0d beats: %0d throws counted, %0d games scored,",
             beats_sent, throws_counted, games_scored);
    $display("limits swept to both extremes, with long output hold-off and drained pauses");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/crte_pkg.sv
sv/craps_randomness_test_engine.sv
sv/crte_checker.sv
tb/craps_checker.sv
tb/testbench.sv
